// ===== src/swac_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, register indexes and defaults for the square window average counter.
package swac_pkg;

    localparam int ELEM_W      = 16;  // one matrix element
    localparam int SIZE_W      = 7;   // row_count / col_count registers
    localparam int TH_W        = 16;  // min_average register
    localparam int CNT_W       = 17;  // window_count result
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AVERAGE = 2'd2;

endpackage

// ===== src/square_window_average_counter_unit.sv =====
`timescale 1ns / 1ps
// Top level: summed-area table loader and square window threshold counter.
//
// Usage:
//   Write row_count (index 0), col_count (index 1) and min_average (index 2)
//   on the cfg port while the block is idle; any write restarts the matrix.
//   Sizes of zero act as one, sizes above MAX_ROWS / MAX_COLS act as the max.
//   Stream the matrix row-major on s_axis, one element per beat. While
//   loading, s_axis_tready stays high and one beat is taken every cycle.
//   After the last beat the block scans every square window, stepping through
//   phases T0, T1, T2, T3 and CMP per window on a single table read port and
//   one add/sub unit, over N = sum over s of (rows-s+1)*(cols-s+1) windows.
//   When the scan ends and the output register is free, the count appears on
//   m_axis and s_axis_tready returns high in that same cycle.
//   A result waiting on m_axis does not block loading of the next matrix;
//   if a second scan ends before the first result is taken, the block holds
//   with s_axis_tready low until the output register frees up.
//   Reset clears the position and output and restores a 1 x 1 matrix with
//   threshold zero; table contents are not cleared, only written entries
//   are ever read.
module square_window_average_counter_unit #(
    parameter int MAX_ROWS = swac_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = swac_pkg::DEF_MAX_COLS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [swac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swac_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [swac_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [15:0] element
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [swac_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // [16:0] window_count
);
    import swac_pkg::*;

    localparam int RIW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RNW     = $clog2(MAX_ROWS + 1);
    localparam int CNW     = $clog2(MAX_COLS + 1);
    localparam int MIN_DIM = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int SNW     = $clog2(MIN_DIM + 1);
    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW      = ELEM_W + $clog2(DEPTH);
    localparam int RSW     = ELEM_W + $clog2(MAX_COLS);
    localparam int ACC_W   = TW + 1;
    localparam int AREA_W  = 2 * SNW;
    localparam int PROD_W  = TH_W + AREA_W;
    localparam int CMP_W   = (ACC_W > PROD_W) ? ACC_W : PROD_W;
    localparam int DIM_W   = SIZE_W + 2;

    // scan phases: issue one table read per phase, accumulate the previous one
    localparam logic [2:0] PH_T0  = 3'd0;
    localparam logic [2:0] PH_T1  = 3'd1;
    localparam logic [2:0] PH_T2  = 3'd2;
    localparam logic [2:0] PH_T3  = 3'd3;
    localparam logic [2:0] PH_CMP = 3'd4;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [SIZE_W-1:0]    row_count_reg;
    logic [SIZE_W-1:0]    col_count_reg;
    logic [TH_W-1:0]      min_avg_reg;

    logic [RIW-1:0]       load_row_reg;
    logic [CIW-1:0]       load_col_reg;
    logic [RSW-1:0]       row_sum_reg;
    logic [RIW-1:0]       load_row_next;
    logic [CIW-1:0]       load_col_next;
    logic [RSW-1:0]       row_sum_next;

    logic [SNW-1:0]       s_reg;
    logic [RNW-1:0]       i_reg;
    logic [CNW-1:0]       j_reg;
    logic [2:0]           phase_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [AREA_W-1:0]    area_reg;
    logic [PROD_W-1:0]    thr_area_reg;

    logic                 out_valid_reg;
    logic [CNT_W-1:0]     out_data_reg;

    logic [TW-1:0]        mem [DEPTH];
    logic [TW-1:0]        rd_data_reg;
    logic                 rd_zero_reg;
    logic                 fwd_hit_reg;
    logic [TW-1:0]        fwd_data_reg;

    logic [RNW-1:0]       rows_eff;
    logic [CNW-1:0]       cols_eff;
    logic [SNW-1:0]       lim_eff;
    logic                 in_accept;
    logic                 col_last;
    logic                 row_last;
    logic                 frame_last;
    logic [RSW-1:0]       new_sum;
    logic [TW-1:0]        above;
    logic [TW-1:0]        entry;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic                 rd_sel_load;
    logic [AW-1:0]        rd_addr;
    logic                 rd_zero;
    logic [RNW-1:0]       term_row;
    logic [CNW-1:0]       term_col;
    logic [ACC_W-1:0]     term;
    logic [ACC_W-1:0]     acc_base;
    logic [ACC_W-1:0]     box;
    logic                 meets;
    logic                 win_last;
    logic                 scan_end;
    logic                 out_load;

    // effective sizes: zero acts as one, oversize clamps to the maximum
    always_comb
    begin
        if (row_count_reg == '0)
            rows_eff = RNW'(1);
        else if (DIM_W'(row_count_reg) > DIM_W'(MAX_ROWS))
            rows_eff = RNW'(MAX_ROWS);
        else
            rows_eff = RNW'(row_count_reg);

        if (col_count_reg == '0)
            cols_eff = CNW'(1);
        else if (DIM_W'(col_count_reg) > DIM_W'(MAX_COLS))
            cols_eff = CNW'(MAX_COLS);
        else
            cols_eff = CNW'(col_count_reg);

        if (DIM_W'(rows_eff) < DIM_W'(cols_eff))
            lim_eff = SNW'(rows_eff);
        else
            lim_eff = SNW'(cols_eff);
    end

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign col_last      = ((CNW'(load_col_reg) + CNW'(1)) == cols_eff);
    assign row_last      = ((RNW'(load_row_reg) + RNW'(1)) == rows_eff);
    assign frame_last    = in_accept && col_last && row_last && !cfg_wr_en;

    assign new_sum = row_sum_reg + RSW'(s_axis_tdata[ELEM_W-1:0]);
    assign above   = rd_zero_reg ? '0 : (fwd_hit_reg ? fwd_data_reg : rd_data_reg);
    assign entry   = TW'(new_sum) + above;
    assign wr_en   = in_accept && !cfg_wr_en;
    assign wr_addr = AW'(int'(load_row_reg) * MAX_COLS + int'(load_col_reg));

    // load position for the next beat
    always_comb
    begin
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        row_sum_next  = row_sum_reg;
        if (cfg_wr_en)
        begin
            load_row_next = '0;
            load_col_next = '0;
            row_sum_next  = '0;
        end
        else if (in_accept)
        begin
            if (col_last)
            begin
                load_col_next = '0;
                row_sum_next  = '0;
                load_row_next = row_last ? '0 : load_row_reg + RIW'(1);
            end
            else
            begin
                load_col_next = load_col_reg + CIW'(1);
                row_sum_next  = new_sum;
            end
        end
    end

    // scan term: (i,j) and (i-s,j-s) add, (i-s,j) and (i,j-s) subtract
    always_comb
    begin
        unique case (phase_reg)
            PH_T1:
            begin
                term_row = i_reg - RNW'(s_reg);
                term_col = j_reg - CNW'(s_reg);
            end
            PH_T2:
            begin
                term_row = i_reg - RNW'(s_reg);
                term_col = j_reg;
            end
            PH_T3:
            begin
                term_row = i_reg;
                term_col = j_reg - CNW'(s_reg);
            end
            default:
            begin
                term_row = i_reg;
                term_col = j_reg;
            end
        endcase
    end

    assign win_last = (s_reg == lim_eff) && (i_reg == rows_eff) && (j_reg == cols_eff);
    assign scan_end = (state_reg == ST_SCAN) && (phase_reg == PH_CMP) && win_last;
    assign rd_sel_load = (state_reg != ST_SCAN) || scan_end;

    // load mode reads the entry above the next position, so data lines up with it
    always_comb
    begin
        if (rd_sel_load)
        begin
            rd_zero = (load_row_next == '0);
            rd_addr = AW'((int'(load_row_next) - 1) * MAX_COLS + int'(load_col_next));
        end
        else
        begin
            rd_zero = (term_row == '0) || (term_col == '0);
            rd_addr = AW'((int'(term_row) - 1) * MAX_COLS + int'(term_col) - 1);
        end
    end

    assign term     = rd_zero_reg ? '0 : ACC_W'(rd_data_reg);
    assign acc_base = (phase_reg == PH_T1) ? '0 : acc_reg;
    assign box      = ((phase_reg == PH_T3) || (phase_reg == PH_CMP)) ?
                      acc_base - term : acc_base + term;
    // floor(box / s^2) >= th  <=>  box >= th * s^2
    assign meets    = (CMP_W'(box) >= CMP_W'(thr_area_reg));

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    // table memory with a registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= entry;
        rd_data_reg <= mem[rd_addr];
    end

    // payload pipeline: forward data, window area, scaled threshold and accumulator
    always_ff @(posedge clk)
    begin
        fwd_data_reg <= entry;
        area_reg     <= AREA_W'(s_reg) * AREA_W'(s_reg);
        thr_area_reg <= PROD_W'(min_avg_reg) * PROD_W'(area_reg);
        acc_reg      <= box;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_zero_reg <= 1'b1;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            rd_zero_reg <= rd_zero;
            // one-column matrices read the row just written
            fwd_hit_reg <= wr_en && rd_sel_load && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= SIZE_W'(1);
            col_count_reg <= SIZE_W'(1);
            min_avg_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT:   row_count_reg <= cfg_data[SIZE_W-1:0];
                CFG_COL_COUNT:   col_count_reg <= cfg_data[SIZE_W-1:0];
                CFG_MIN_AVERAGE: min_avg_reg   <= cfg_data[TH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            row_sum_reg   <= '0;
            s_reg         <= SNW'(1);
            i_reg         <= RNW'(1);
            j_reg         <= CNW'(1);
            phase_reg     <= PH_T0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
            row_sum_reg  <= row_sum_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (frame_last)
                    begin
                        state_reg <= ST_SCAN;
                        s_reg     <= SNW'(1);
                        i_reg     <= RNW'(1);
                        j_reg     <= CNW'(1);
                        phase_reg <= PH_T0;
                        cnt_reg   <= '0;
                    end
                end
                ST_SCAN:
                begin
                    if (phase_reg != PH_CMP)
                        phase_reg <= phase_reg + 3'd1;
                    else
                    begin
                        phase_reg <= PH_T0;
                        cnt_reg   <= cnt_reg + CNT_W'(meets);
                        if (j_reg != cols_eff)
                            j_reg <= j_reg + CNW'(1);
                        else if (i_reg != rows_eff)
                        begin
                            i_reg <= i_reg + RNW'(1);
                            j_reg <= CNW'(s_reg);
                        end
                        else if (s_reg != lim_eff)
                        begin
                            s_reg <= s_reg + SNW'(1);
                            i_reg <= RNW'(s_reg) + RNW'(1);
                            j_reg <= CNW'(s_reg) + CNW'(1);
                        end
                        else
                            state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    // hold until the output register is free
                    if (out_load)
                    begin
                        out_data_reg <= cnt_reg;
                        state_reg    <= ST_LOAD;
                    end
                end
                default:
                    state_reg <= ST_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);

endmodule

// ===== src/swac_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the square window average counter, bound to the top level.
module swac_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [swac_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // [16:0] window_count
);
    import swac_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // padding above the count stays zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:CNT_W] == '0))
        else $error("result padding bits set");

    // input side closes only right after an accepted beat, the last one of a matrix
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("input ready dropped without a preceding beat");

    // a new result follows a scan, never an input beat directly
    a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result raised right after an input beat");

endmodule

bind square_window_average_counter_unit swac_checker u_swac_checker (.*);

// ===== bench/square_window_average_counter_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench: streams random matrices, predicts each window count, checks every beat.
module square_window_average_counter_unit_tb;
    import swac_pkg::*;

    localparam int MAX_R      = DEF_MAX_ROWS;
    localparam int MAX_C      = DEF_MAX_COLS;
    localparam int LONG_HOLD  = 600;
    localparam int SETTLE     = 8;
    localparam int ITEM_GOAL  = 500;
    localparam int MATRIX_GOAL = 40;
    localparam int CYCLE_LIMIT = 2_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {FILL_ANY, FILL_NEAR, FILL_EDGE} fill_kind_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;   // [15:0] element
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;       // [16:0] window_count

    // stimulus and expected results
    logic [ELEM_W-1:0] element_q[$];
    logic [CNT_W-1:0] window_count_q[$];
    int mismatch_count = 0;
    int items_sent = 0;
    int matrices_done = 0;
    int cycle_count = 0;

    // handshake pacing
    int unsigned send_wait = 0;
    bit send_burst = 1'b0;
    int unsigned recv_wait = 0;
    bit recv_burst = 1'b0;
    int unsigned hold_left = 0;
    logic hold_start = 1'b0;
    logic hold_used = 1'b0;

    // predictor state: summed-area table, load position, registers
    logic [27:0] sat_mem [0:MAX_R*MAX_C-1];
    logic [21:0] row_sum = '0;
    int unsigned load_r = 0;
    int unsigned load_c = 0;
    logic [SIZE_W-1:0] rows_reg = 7'd1;
    logic [SIZE_W-1:0] cols_reg = 7'd1;
    logic [TH_W-1:0] thr_reg = '0;

    square_window_average_counter_unit #(
        .MAX_ROWS(MAX_R),
        .MAX_COLS(MAX_C)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #4 clk = ~clk;

    function automatic int unsigned eff_size(input logic [SIZE_W-1:0] raw,
                                             input int unsigned cap);
        if (raw == 0)
            return 1;
        if (raw > cap)
            return cap;
        return raw;
    endfunction

    function automatic void restart_fill();
        row_sum = '0;
        load_r = 0;
        load_c = 0;
    endfunction

    // 1-based table read; row 0 and column 0 read as zero
    function automatic longint unsigned sat_at(input int unsigned r, input int unsigned c);
        if (r == 0 || c == 0)
            return 0;
        return sat_mem[(r - 1) * MAX_C + c - 1];
    endfunction

    function automatic logic [CNT_W-1:0] count_qualifying(input int unsigned rows,
                                                          input int unsigned cols);
        int unsigned side_lim;
        int unsigned hits;
        int unsigned side;
        int unsigned r;
        int unsigned c;
        longint unsigned box;
        longint unsigned area;
        side_lim = (rows < cols) ? rows : cols;
        hits = 0;
        for (side = 1; side <= side_lim; side++)
        begin
            area = side * side;
            for (r = side; r <= rows; r++)
            begin
                for (c = side; c <= cols; c++)
                begin
                    box = sat_at(r, c) + sat_at(r - side, c - side)
                        - sat_at(r - side, c) - sat_at(r, c - side);
                    if (box / area >= thr_reg)
                        hits++;
                end
            end
        end
        return hits[CNT_W-1:0];
    endfunction

    // load one element; returns 1 with the window count when the matrix completes
    function automatic bit absorb_element(input logic [ELEM_W-1:0] elem,
                                          output logic [CNT_W-1:0] tally);
        int unsigned rows;
        int unsigned cols;
        rows = eff_size(rows_reg, MAX_R);
        cols = eff_size(cols_reg, MAX_C);
        tally = '0;
        if (load_r >= rows || load_c >= cols)
            restart_fill();
        row_sum = row_sum + 22'(elem);
        sat_mem[load_r * MAX_C + load_c] = 28'(row_sum + sat_at(load_r, load_c + 1));
        if (load_c + 1 < cols)
        begin
            load_c++;
            return 1'b0;
        end
        load_c = 0;
        row_sum = '0;
        if (load_r + 1 < rows)
        begin
            load_r++;
            return 1'b0;
        end
        load_r = 0;
        tally = count_qualifying(rows, cols);
        return 1'b1;
    endfunction

    function automatic int unsigned draw_gap(input bit burst);
        if (burst)
            return 0;
        return $urandom_range(18, 0);
    endfunction

    function automatic logic [ELEM_W-1:0] draw_element(input fill_kind_t kind,
                                                       input logic [TH_W-1:0] thr);
        int unsigned lo;
        int unsigned hi;
        lo = thr / 2;
        hi = thr + thr / 2 + 1;
        if (hi > 65535)
            hi = 65535;
        case (kind)
            FILL_NEAR: return ELEM_W'($urandom_range(hi, lo));
            FILL_EDGE: return ($urandom_range(1, 0) != 0) ? 16'hFFFF : 16'h0000;
            default:   return ELEM_W'($urandom());
        endcase
    endfunction

    function automatic logic [TH_W-1:0] draw_threshold();
        case ($urandom_range(5, 0))
            0: return '0;
            1: return 16'hFFFF;
            2: return TH_W'($urandom_range(300, 0));
            default: return TH_W'($urandom());
        endcase
    endfunction

    // size register value, sometimes zero, sometimes with junk above bit 6
    function automatic logic [CFG_DATA_W-1:0] draw_size();
        logic [CFG_DATA_W-1:0] val;
        case ($urandom_range(9, 0))
            0: val = '0;
            1: val = CFG_DATA_W'($urandom_range(10, 7));
            default: val = CFG_DATA_W'($urandom_range(6, 1));
        endcase
        if ($urandom_range(3, 0) == 0)
            val = val | CFG_DATA_W'($urandom() & 32'hFF80);
        return val;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_ROW_COUNT:   rows_reg = val[SIZE_W-1:0];
            CFG_COL_COUNT:   cols_reg = val[SIZE_W-1:0];
            CFG_MIN_AVERAGE: thr_reg = val[TH_W-1:0];
            default: ;
        endcase
        restart_fill();
    endtask

    task automatic apply_setup(input logic [CFG_DATA_W-1:0] rows_val,
                               input logic [CFG_DATA_W-1:0] cols_val,
                               input logic [TH_W-1:0] thr);
        write_reg(CFG_ROW_COUNT, rows_val);
        write_reg(CFG_COL_COUNT, cols_val);
        write_reg(CFG_MIN_AVERAGE, thr);
        if ($urandom_range(4, 0) == 0)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_matrix(input int unsigned count, input fill_kind_t kind,
                                input bit complete);
        int unsigned k;
        for (k = 0; k < count; k++)
            element_q.push_back(draw_element(kind, thr_reg));
        items_sent += count;
        if (complete)
            matrices_done++;
    endtask

    // hold until every beat is taken and every count has come back
    task automatic await_idle();
        do
            @(posedge clk);
        while (element_q.size() != 0 || s_axis_tvalid || window_count_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            send_wait <= 0;
            send_burst <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (send_wait != 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (element_q.size() != 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= element_q.pop_front();
                send_wait <= draw_gap(send_burst);
                if ($urandom_range(29, 0) == 0)
                    send_burst <= !send_burst;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : recv_proc
        int unsigned stall;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_wait <= 0;
            hold_left <= 0;
            hold_used <= 1'b0;
            recv_burst <= 1'b0;
        end
        else if (hold_start && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= (hold_left == 1);
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            stall = draw_gap(recv_burst);
            recv_wait <= stall;
            m_axis_tready <= (stall == 0);
            if ($urandom_range(14, 0) == 0)
                recv_burst <= !recv_burst;
        end
        else if (recv_wait != 0)
        begin
            recv_wait <= recv_wait - 1;
            m_axis_tready <= (recv_wait == 1);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_proc
        logic [CNT_W-1:0] tally;
        logic [CNT_W-1:0] want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (window_count_q.size() == 0)
                begin
                    $error("window_count: expected none, got %0d", m_axis_tdata[CNT_W-1:0]);
                    mismatch_count++;
                end
                else
                begin
                    want = window_count_q.pop_front();
                    if (m_axis_tdata[CNT_W-1:0] !== want)
                    begin
                        $error("window_count: expected %0d, got %0d",
                               want, m_axis_tdata[CNT_W-1:0]);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (absorb_element(s_axis_tdata[ELEM_W-1:0], tally))
                    window_count_q.push_back(tally);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] rows_val;
        logic [CFG_DATA_W-1:0] cols_val;
        int unsigned cells;
        int unsigned n_mat;
        int unsigned m;
        fill_kind_t kind;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // 1 x 1 at reset with zero threshold: every window counts
        element_q.push_back(16'hFFFF);
        element_q.push_back(16'h0000);
        items_sent += 2;
        matrices_done += 2;
        await_idle();

        // top threshold: only all-max windows reach it
        apply_setup(16'd2, 16'd2, 16'hFFFF);
        repeat (4) element_q.push_back(16'hFFFF);
        element_q.push_back(16'hFFFF);
        element_q.push_back(16'hFFFF);
        element_q.push_back(16'hFFFF);
        element_q.push_back(16'hFFFE);
        items_sent += 8;
        matrices_done += 2;
        await_idle();

        // zero row count acts as one; high bits of the column value are dropped
        apply_setup(16'd0, 16'hFF83, 16'd1);
        element_q.push_back(16'd0);
        element_q.push_back(16'd1);
        element_q.push_back(16'd2);
        items_sent += 3;
        matrices_done++;
        await_idle();

        // write to an unused index aborts a half-loaded matrix
        apply_setup(16'd2, 16'd2, 16'd0);
        queue_matrix(2, FILL_ANY, 1'b0);
        await_idle();
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        queue_matrix(4, FILL_ANY, 1'b1);
        await_idle();

        // oversized row count acts as the maximum; widest column count
        apply_setup(16'h007F, 16'd2, draw_threshold());
        queue_matrix(MAX_R * 2, FILL_NEAR, 1'b1);
        await_idle();
        apply_setup(16'd1, 16'd64, draw_threshold());
        queue_matrix(MAX_C, FILL_NEAR, 1'b1);
        await_idle();

        // receiver holds off long while several matrices queue up behind it
        apply_setup(16'd2, 16'd2, draw_threshold());
        @(posedge clk);
        hold_start <= 1'b1;
        for (m = 0; m < 4; m++)
            queue_matrix(4, FILL_NEAR, 1'b1);
        await_idle();

        while (items_sent < ITEM_GOAL || matrices_done < MATRIX_GOAL)
        begin
            rows_val = draw_size();
            cols_val = draw_size();
            if ($urandom_range(15, 0) == 0)
            begin
                rows_val = CFG_DATA_W'($urandom_range(127, 64));
                cols_val = CFG_DATA_W'($urandom_range(1, 0));
            end
            apply_setup(rows_val, cols_val, draw_threshold());
            cells = eff_size(rows_val[SIZE_W-1:0], MAX_R) * eff_size(cols_val[SIZE_W-1:0], MAX_C);
            kind = fill_kind_t'($urandom_range(2, 0));
            n_mat = $urandom_range(3, 1);
            for (m = 0; m < n_mat; m++)
            begin
                queue_matrix(cells, kind, 1'b1);
                if ($urandom_range(4, 0) == 0)
                    await_idle();
            end
            // leave a partial matrix for the next register write to abort
            if (cells > 1 && $urandom_range(5, 0) == 0)
                queue_matrix($urandom_range(cells - 1, 1), kind, 1'b0);
            await_idle();
        end

        await_idle();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && window_count_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
